[rtl/core/rccl_pkg.sv]
// Package with constants, codes and table entry types for the rune class and case lookup.
package rccl_pkg;

	localparam int ASCII_SIZE    = 256;
	localparam int MAX_RANGES    = 512;
	localparam int MAX_CASE_MAPS = 512;
	localparam int TYPE_DEPTH    = 16384;

	localparam int ASCII_AW = $clog2(ASCII_SIZE);
	localparam int RANGE_AW = $clog2(MAX_RANGES);
	localparam int MAP_AW   = $clog2(MAX_CASE_MAPS);
	localparam int TYPE_AW  = $clog2(TYPE_DEPTH);
	localparam int CNT_W    = 10;
	localparam int TDW_W    = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [3:0] {
		K_CLASS_Q   = 4'd0,
		K_LOWER_Q   = 4'd1,
		K_UPPER_Q   = 4'd2,
		K_WR_ACLASS = 4'd3,
		K_WR_ALOWER = 4'd4,
		K_WR_AUPPER = 4'd5,
		K_WR_RANGE  = 4'd6,
		K_WR_LMAP   = 4'd7,
		K_WR_UMAP   = 4'd8,
		K_WR_TYPE   = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		CFG_RANGE_COUNT = 2'd0,
		CFG_LOWER_COUNT = 2'd1,
		CFG_UPPER_COUNT = 2'd2,
		CFG_TYPE_WORDS  = 2'd3
	} cfg_idx_t;

	// One class range entry as stored in memory.
	typedef struct packed {
		logic [30:0]      first;
		logic [30:0]      last;
		logic [31:0]      mask;
		logic [TYPE_AW-1:0] type_base;
		logic             typed;
	} class_entry_t;

	// One case map entry as stored in memory.
	typedef struct packed {
		logic [30:0] first;
		logic [30:0] last;
		logic [31:0] base;
	} case_entry_t;

	// Saturate a count register to a table depth.
	function automatic logic [CNT_W:0] sat_cnt(input logic [CNT_W-1:0] v, input int lim);
		logic [CNT_W:0] r;
		begin
			r = (32'(v) > lim) ? (CNT_W+1)'(lim) : {1'b0, v};
			return r;
		end
	endfunction

endpackage

[rtl/core/rccl_search.sv]
// Binary search sequencer for a sorted table; each memory probe runs ADDR, WAIT, CMP.
module rccl_search (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [rccl_pkg::CNT_W:0] count,
	input  logic [30:0]          cp,
	input  logic [30:0]          e_first,
	input  logic [30:0]          e_last,
	output logic [rccl_pkg::RANGE_AW-1:0] idx,
	output logic                 probe,
	output logic                 done,
	output logic                 hit
);
	import rccl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADDR = 4'b0010,
		S_WAIT = 4'b0100,
		S_CMP  = 4'b1000
	} sstate_t;

	sstate_t state_q;
	logic [CNT_W:0] lo_q, lim_q;
	logic [CNT_W:0] mid;

	assign mid   = lo_q + (lim_q >> 1);
	assign idx   = mid[RANGE_AW-1:0];
	assign probe = (state_q == S_ADDR);

	// Search state: probe the middle entry, then narrow the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lo_q    <= '0;
			lim_q   <= '0;
			done    <= 1'b0;
			hit     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						lo_q    <= '0;
						lim_q   <= count;
						hit     <= 1'b0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					if (lim_q == '0 || 32'(mid) >= MAX_RANGES) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_CMP;
				S_CMP: begin
					if (cp <= e_last) begin
						if (cp >= e_first) begin
							hit     <= 1'b1;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							lim_q   <= lim_q >> 1;
							state_q <= S_ADDR;
						end
					end else begin
						lo_q    <= mid + 1'b1;
						lim_q   <= (lim_q - 1'b1) >> 1;
						state_q <= S_ADDR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/rune_class_and_case_lookup.sv]
// Rune class and case lookup: table memories, write handling and query sequencing.
// One item is taken at a time. A write item leaves the sequencer idle, so writes can follow back
// to back. A query below 256 reads the ASCII table through the ASC and ASCW states, and a
// negative one goes straight to the output; a higher code point runs a binary search over
// the class or case table with one synchronous memory read per probe, and a typed class
// word adds one more read from the type table.
// The answer waits in an output register; the next item is taken once it is delivered.
module rune_class_and_case_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [rccl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rccl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [31:0] code_point,
	input  logic [13:0] slot,
	input  logic [30:0] range_first,
	input  logic [30:0] range_last,
	input  logic [31:0] word,
	input  logic        has_types,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] answer
);
	import rccl_pkg::*;

	typedef enum logic [6:0] {
		T_IDLE  = 7'b0000001,
		T_ASC   = 7'b0000010,
		T_ASCW  = 7'b0000100,
		T_SRCH  = 7'b0001000,
		T_TYPE  = 7'b0010000,
		T_TYPEW = 7'b0100000,
		T_OUT   = 7'b1000000
	} tstate_t;

	// Configuration registers.
	logic [CNT_W-1:0] range_count_q, lower_count_q, upper_count_q;
	logic [TDW_W-1:0] type_data_words_q;
	logic [TDW_W-1:0] next_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count_q     <= '0;
			lower_count_q     <= '0;
			upper_count_q     <= '0;
			type_data_words_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_RANGE_COUNT: range_count_q <= cfg_data[CNT_W-1:0];
				CFG_LOWER_COUNT: lower_count_q <= cfg_data[CNT_W-1:0];
				CFG_UPPER_COUNT: upper_count_q <= cfg_data[CNT_W-1:0];
				CFG_TYPE_WORDS:  type_data_words_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories.
	logic [31:0]  ascii_class_m [ASCII_SIZE];
	logic [31:0]  ascii_lower_m [ASCII_SIZE];
	logic [31:0]  ascii_upper_m [ASCII_SIZE];
	class_entry_t range_m [MAX_RANGES];
	case_entry_t  lmap_m  [MAX_CASE_MAPS];
	case_entry_t  umap_m  [MAX_CASE_MAPS];
	logic [31:0]  type_m  [TYPE_DEPTH];

	tstate_t     state_q;
	logic [3:0]  kind_q;
	logic [31:0] cp_q;
	logic [31:0] answer_q;
	logic [31:0] asc_rd_q;
	class_entry_t range_rd_q;
	case_entry_t  lmap_rd_q, umap_rd_q;
	logic [31:0] type_rd_q;
	logic [TYPE_AW-1:0] type_addr_q;

	logic accept;
	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid && !in_stall;

	// Search unit shared by the three range tables.
	logic srch_start, srch_probe, srch_done, srch_hit;
	logic [RANGE_AW-1:0] srch_idx;
	logic [CNT_W:0] srch_count;
	logic [30:0] e_first, e_last;

	always_comb begin
		case (kind_q)
			K_LOWER_Q: begin
				srch_count = sat_cnt(lower_count_q, MAX_CASE_MAPS);
				e_first = lmap_rd_q.first; e_last = lmap_rd_q.last;
			end
			K_UPPER_Q: begin
				srch_count = sat_cnt(upper_count_q, MAX_CASE_MAPS);
				e_first = umap_rd_q.first; e_last = umap_rd_q.last;
			end
			default: begin
				srch_count = sat_cnt(range_count_q, MAX_RANGES);
				e_first = range_rd_q.first; e_last = range_rd_q.last;
			end
		endcase
	end

	rccl_search u_search (
		.clk(clk), .arst_n(arst_n), .start(srch_start), .count(srch_count),
		.cp(cp_q[30:0]), .e_first(e_first), .e_last(e_last), .idx(srch_idx),
		.probe(srch_probe), .done(srch_done), .hit(srch_hit)
	);

	// Range write: allocate type words if they fit.
	logic [31:0] need;
	logic [31:0] avail;
	logic        claim;
	assign need  = 32'(range_last - range_first) + 32'd1;
	assign avail = (32'(type_data_words_q) > TYPE_DEPTH) ? 32'(TYPE_DEPTH)
		: 32'(type_data_words_q);
	assign claim = has_types && (range_last >= range_first)
		&& (33'(next_type_q) + 33'(need) <= 33'(avail));

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (kind)
				K_WR_ACLASS: if (slot < 14'(ASCII_SIZE)) ascii_class_m[slot[ASCII_AW-1:0]] <= word;
				K_WR_ALOWER: if (slot < 14'(ASCII_SIZE)) ascii_lower_m[slot[ASCII_AW-1:0]] <= word;
				K_WR_AUPPER: if (slot < 14'(ASCII_SIZE)) ascii_upper_m[slot[ASCII_AW-1:0]] <= word;
				K_WR_RANGE: if (slot < 14'(MAX_RANGES))
					range_m[slot[RANGE_AW-1:0]] <= '{first: range_first, last: range_last,
						mask: word, type_base: claim ? next_type_q[TYPE_AW-1:0] : '0,
						typed: claim};
				K_WR_LMAP: if (slot < 14'(MAX_CASE_MAPS))
					lmap_m[slot[MAP_AW-1:0]] <= '{first: range_first, last: range_last, base: word};
				K_WR_UMAP: if (slot < 14'(MAX_CASE_MAPS))
					umap_m[slot[MAP_AW-1:0]] <= '{first: range_first, last: range_last, base: word};
				K_WR_TYPE: type_m[slot[TYPE_AW-1:0]] <= word;
				default: ;
			endcase
		end
		if (state_q == T_ASC) begin
			case (kind_q)
				K_LOWER_Q: asc_rd_q <= ascii_lower_m[cp_q[ASCII_AW-1:0]];
				K_UPPER_Q: asc_rd_q <= ascii_upper_m[cp_q[ASCII_AW-1:0]];
				default:   asc_rd_q <= ascii_class_m[cp_q[ASCII_AW-1:0]];
			endcase
		end
		if (srch_probe) begin
			range_rd_q <= range_m[srch_idx];
			lmap_rd_q  <= lmap_m[srch_idx[MAP_AW-1:0]];
			umap_rd_q  <= umap_m[srch_idx[MAP_AW-1:0]];
		end
		if (state_q == T_TYPE) type_rd_q <= type_m[type_addr_q];
	end

	// Type word address for a typed class hit.
	logic [31:0] type_at;
	assign type_at = 32'(range_rd_q.type_base) + 32'(cp_q[30:0] - range_rd_q.first);

	// Control sequencer.
	assign srch_start = (state_q == T_SRCH) && !srch_probe && !srch_done;
	logic srch_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			next_type_q <= '0;
			srch_busy_q <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						kind_q <= kind;
						cp_q   <= code_point;
						if (kind == K_WR_RANGE && slot < 14'(MAX_RANGES) && claim)
							next_type_q <= next_type_q + TDW_W'(need);
						if (kind == K_CLASS_Q || kind == K_LOWER_Q || kind == K_UPPER_Q) begin
							if (code_point[31]) begin
								answer_q <= (kind == K_CLASS_Q) ? 32'd0 : code_point;
								state_q  <= T_OUT;
							end else if (code_point < 32'(ASCII_SIZE)) begin
								state_q <= T_ASC;
							end else begin
								srch_busy_q <= 1'b0;
								state_q     <= T_SRCH;
							end
						end
					end
				end
				T_ASC: state_q <= T_ASCW;
				T_ASCW: begin
					answer_q <= asc_rd_q;
					state_q  <= T_OUT;
				end
				T_SRCH: begin
					if (srch_start) srch_busy_q <= 1'b1;
					if (srch_done && srch_busy_q) begin
						srch_busy_q <= 1'b0;
						if (kind_q == K_CLASS_Q) begin
							if (!srch_hit) begin
								answer_q <= 32'd0;
								state_q  <= T_OUT;
							end else if (!range_rd_q.typed) begin
								answer_q <= range_rd_q.mask;
								state_q  <= T_OUT;
							end else if (type_at < 32'(TYPE_DEPTH)) begin
								type_addr_q <= type_at[TYPE_AW-1:0];
								state_q     <= T_TYPE;
							end else begin
								answer_q <= 32'd0;
								state_q  <= T_OUT;
							end
						end else begin
							if (!srch_hit) answer_q <= cp_q;
							else if (kind_q == K_LOWER_Q)
								answer_q <= lmap_rd_q.base + (cp_q - {1'b0, lmap_rd_q.first});
							else
								answer_q <= umap_rd_q.base + (cp_q - {1'b0, umap_rd_q.first});
							state_q <= T_OUT;
						end
					end
				end
				T_TYPE: state_q <= T_TYPEW;
				T_TYPEW: begin
					answer_q <= type_rd_q;
					state_q  <= T_OUT;
				end
				T_OUT: if (!out_stall) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == T_OUT);
	assign answer    = answer_q;
endmodule

[rtl/core/rccl_checker.sv]
// Port checker for the rune class and case lookup, bound to the top level.
module rccl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [3:0]  kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] answer
);
	import rccl_pkg::*;

	// A result word holds while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(answer))
		else $error("answer changed while stalled");

	// No new word is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// Accepting a query word closes the input next cycle.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == K_CLASS_Q || kind == K_LOWER_Q
			|| kind == K_UPPER_Q) |=> in_stall)
		else $error("input not closed after query accept");

	// After delivery the result channel goes quiet.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");
endmodule

bind rune_class_and_case_lookup rccl_checker u_rccl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
	.out_valid(out_valid), .out_stall(out_stall), .answer(answer)
);

[tb/tb_top.sv]
// Testbench for the rune class and case lookup: table loads, queries and a checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rccl_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD = 300;
	localparam int ASC_LOW_END = 16;
	localparam int ASC_HIGH_START = 240;
	localparam int BIG_TABLE = 40;
	localparam logic [3:0] KIND_UNUSED_FIRST = 4'd10;
	localparam logic [3:0] KIND_UNUSED_LAST = 4'd15;

	typedef struct {
		logic [3:0]  kind;
		logic [31:0] cp;
		logic [13:0] slot;
		logic [30:0] first;
		logic [30:0] last;
		logic [31:0] word;
		logic        has_types;
	} rune_word_t;

	typedef struct {
		logic [31:0] first;
		logic [31:0] last;
		logic [31:0] mask;
		int unsigned tbase;
		bit          typed;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [14:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  kind = '0;
	logic [31:0] code_point = '0;
	logic [13:0] slot = '0;
	logic [30:0] range_first = '0;
	logic [30:0] range_last = '0;
	logic [31:0] word = '0;
	logic        has_types = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] answer;

	rune_class_and_case_lookup dut (.*);

	always #2 clk = ~clk;

	// Shadow copy of the lookup tables and registers.
	logic [31:0] asc_class [ASCII_SIZE];
	logic [31:0] asc_lower [ASCII_SIZE];
	logic [31:0] asc_upper [ASCII_SIZE];
	span_t       class_spans [MAX_RANGES];
	span_t       lower_spans [MAX_CASE_MAPS];
	span_t       upper_spans [MAX_CASE_MAPS];
	logic [31:0] type_store [TYPE_DEPTH];
	int unsigned span_cnt, lower_cnt, upper_cnt, type_avail, next_type;
	int unsigned types_filled;

	logic [31:0] answers_due [$];
	int errors = 0;
	int n_queries = 0, n_writes = 0, n_cfg = 0, n_checked = 0;
	int burst_left = 0;
	int gap_max = 4;
	int stall_mode = 0;
	int hold_left = 0;
	bit hold_req = 0;
	int idle_cycles = 0;

	function automatic int unsigned clip(input int unsigned v, input int unsigned lim);
		return v > lim ? lim : v;
	endfunction

	// Binary search over the class ranges.
	function automatic logic [31:0] class_of(input logic [31:0] cp);
		int unsigned lo, lim, idx;
		longint unsigned at;
		lo = 0;
		lim = clip(span_cnt, MAX_RANGES);
		while (lim != 0) begin
			idx = lo + (lim >> 1);
			if (idx >= MAX_RANGES) return 0;
			if (cp <= class_spans[idx].last) begin
				if (cp >= class_spans[idx].first) begin
					if (class_spans[idx].typed) begin
						at = longint'(class_spans[idx].tbase) + (cp - class_spans[idx].first);
						return at < TYPE_DEPTH ? type_store[at] : 0;
					end
					return class_spans[idx].mask;
				end
				lim >>= 1;
			end else begin
				lo = idx + 1;
				lim = (lim - 1) >> 1;
			end
		end
		return 0;
	endfunction

	// Binary search over one case map; base plus offset wraps at 32 bits.
	function automatic logic [31:0] case_of(input bit to_upper, input logic [31:0] cp);
		int unsigned lo, lim, idx;
		span_t e;
		lo = 0;
		lim = clip(to_upper ? upper_cnt : lower_cnt, MAX_CASE_MAPS);
		while (lim != 0) begin
			idx = lo + (lim >> 1);
			if (idx >= MAX_CASE_MAPS) return cp;
			e = to_upper ? upper_spans[idx] : lower_spans[idx];
			if (cp <= e.last) begin
				if (cp >= e.first) return e.mask + (cp - e.first);
				lim >>= 1;
			end else begin
				lo = idx + 1;
				lim = (lim - 1) >> 1;
			end
		end
		return cp;
	endfunction

	// Apply one accepted word to the shadow tables; returns 1 if it gives an answer.
	function automatic bit lookup_answer(input rune_word_t w, output logic [31:0] ans);
		bit neg;
		span_t e;
		longint unsigned need;
		neg = w.cp[31];
		ans = '0;
		case (w.kind)
			K_CLASS_Q: begin
				ans = neg ? 32'd0 : (w.cp < ASCII_SIZE ? asc_class[w.cp[7:0]] : class_of(w.cp));
				return 1;
			end
			K_LOWER_Q, K_UPPER_Q: begin
				if (neg) ans = w.cp;
				else if (w.cp < ASCII_SIZE)
					ans = (w.kind == K_LOWER_Q) ? asc_lower[w.cp[7:0]] : asc_upper[w.cp[7:0]];
				else ans = case_of(w.kind == K_UPPER_Q, w.cp);
				return 1;
			end
			K_WR_ACLASS: if (w.slot < ASCII_SIZE) asc_class[w.slot] = w.word;
			K_WR_ALOWER: if (w.slot < ASCII_SIZE) asc_lower[w.slot] = w.word;
			K_WR_AUPPER: if (w.slot < ASCII_SIZE) asc_upper[w.slot] = w.word;
			K_WR_RANGE: if (w.slot < MAX_RANGES) begin
				e.first = {1'b0, w.first};
				e.last = {1'b0, w.last};
				e.mask = w.word;
				e.typed = 0;
				e.tbase = 0;
				if (w.has_types && w.last >= w.first) begin
					need = longint'(w.last - w.first) + 1;
					if (longint'(next_type) + need <= clip(type_avail, TYPE_DEPTH)) begin
						e.typed = 1;
						e.tbase = next_type;
						next_type = next_type + int'(need);
					end
				end
				class_spans[w.slot] = e;
			end
			K_WR_LMAP, K_WR_UMAP: if (w.slot < MAX_CASE_MAPS) begin
				e.first = {1'b0, w.first};
				e.last = {1'b0, w.last};
				e.mask = w.word;
				e.typed = 0;
				e.tbase = 0;
				if (w.kind == K_WR_LMAP) lower_spans[w.slot] = e;
				else upper_spans[w.slot] = e;
			end
			K_WR_TYPE: type_store[w.slot] = w.word;
			default: ;
		endcase
		return 0;
	endfunction

	// Hold the block in reset from the start, then release it.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver stall pattern, with an occasional long hold-off.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 2) != 0);
			endcase
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Compare each delivered answer with the oldest one due.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("answer %h with none due", answer));
			end else begin
				if (answer !== answers_due[0])
					report_mismatch($sformatf("answer %h, due %h", answer, answers_due[0]));
				void'(answers_due.pop_front());
				n_checked++;
			end
		end
	end

	// Watchdog over cycles in which no word moves on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
			$display("rune_class_and_case_lookup regression: fail");
			$finish;
		end
	end

	// Offer one word in bursts with random gaps; returns at the accepting edge.
	task automatic send_word(input rune_word_t w);
		logic [31:0] ans;
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= w.kind;
		code_point <= w.cp;
		slot <= w.slot;
		range_first <= w.first;
		range_last <= w.last;
		word <= w.word;
		has_types <= w.has_types;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (lookup_answer(w, ans)) begin
			answers_due.push_back(ans);
			n_queries++;
		end else n_writes++;
	endtask

	// Stop offering words and wait until every answer has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	// Registers are written only once the block has gone quiet.
	task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RANGE_COUNT: span_cnt = val & 15'h3FF;
			CFG_LOWER_COUNT: lower_cnt = val & 15'h3FF;
			CFG_UPPER_COUNT: upper_cnt = val & 15'h3FF;
			default: type_avail = val;
		endcase
		n_cfg++;
	endtask

	function automatic rune_word_t make_write(input logic [3:0] k, input int unsigned s,
			input logic [31:0] f, input logic [31:0] l, input logic [31:0] wv, input bit ht);
		rune_word_t w;
		w.kind = k;
		w.cp = $urandom();
		w.slot = s[13:0];
		w.first = f[30:0];
		w.last = l[30:0];
		w.word = wv;
		w.has_types = ht;
		return w;
	endfunction

	function automatic rune_word_t make_query(input logic [3:0] k, input logic [31:0] cp);
		rune_word_t w;
		w = make_write(k, $urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 1));
		w.cp = cp;
		return w;
	endfunction

	// Write every type word claimed so far but not yet loaded.
	task automatic fill_type_words();
		while (types_filled < next_type) begin
			send_word(make_write(K_WR_TYPE, types_filled, 0, 0, $urandom(), 0));
			types_filled++;
		end
	endtask

	// Load sorted class ranges and both case maps, n entries each.
	task automatic load_ranges(input int n, input int unsigned max_gap, input int typed_pct);
		logic [31:0] at;
		logic [31:0] f;
		logic [31:0] l;
		for (int t = 0; t < 3; t++) begin
			at = ASCII_SIZE + $urandom_range(0, 64);
			for (int i = 0; i < n; i++) begin
				at = at + $urandom_range(0, max_gap);
				if (at > 32'h7FFF_FF00) at = 32'h7FFF_FF00;
				f = at;
				l = f + $urandom_range(0, (t == 0) ? 7 : 300);
				if ($urandom_range(0, 19) == 0) l = f - 1;
				at = (l >= f ? l : f) + 1;
				case (t)
					0: send_word(make_write(K_WR_RANGE, i, f, l, $urandom(),
						$urandom_range(0, 99) < typed_pct));
					1: send_word(make_write(K_WR_LMAP, i, f, l, $urandom(), 0));
					default: send_word(make_write(K_WR_UMAP, i, f, l, $urandom(), 0));
				endcase
			end
		end
		fill_type_words();
	endtask

	// Pick a code point, half the time inside or just beyond the edges of a loaded entry.
	function automatic logic [31:0] pick_cp(input logic [3:0] k);
		span_t e;
		int unsigned cnt;
		logic [31:0] r;
		cnt = (k == K_CLASS_Q) ? clip(span_cnt, MAX_RANGES)
			: clip(k == K_LOWER_Q ? lower_cnt : upper_cnt, MAX_CASE_MAPS);
		case ($urandom_range(0, 7))
			0: r = $urandom();
			1: r = $urandom_range(0, 1) ? $urandom_range(0, ASC_LOW_END - 1)
				: $urandom_range(ASC_HIGH_START, ASCII_SIZE - 1);
			2: r = 32'h8000_0000 | $urandom();
			3: r = $urandom_range(ASCII_SIZE, 4096);
			default: begin
				if (cnt == 0) r = $urandom_range(0, 1 << 20);
				else begin
					e = (k == K_CLASS_Q) ? class_spans[$urandom_range(0, cnt - 1)]
						: (k == K_LOWER_Q) ? lower_spans[$urandom_range(0, cnt - 1)]
						: upper_spans[$urandom_range(0, cnt - 1)];
					case ($urandom_range(0, 3))
						0: r = e.first - 1;
						1: r = e.last + 1;
						default: r = (e.last >= e.first)
							? e.first + $urandom_range(0, e.last - e.first) : e.first;
					endcase
				end
			end
		endcase
		// Only the low and high ASCII blocks are loaded, so the middle folds to the top.
		if (r >= ASC_LOW_END && r < ASC_HIGH_START) r = 32'(ASC_HIGH_START) + (r & 32'hF);
		return r;
	endfunction

	// Mostly queries, with table rewrites that never leave unwritten words in reach.
	task automatic random_traffic(input int n);
		logic [3:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 85) begin
				k = $urandom_range(K_CLASS_Q, K_UPPER_Q);
				send_word(make_query(k, pick_cp(k)));
			end else begin
				case ($urandom_range(0, 6))
					0: send_word(make_write(K_WR_ACLASS, $urandom_range(0, 300), 0, 0,
						$urandom(), 0));
					1: send_word(make_write(K_WR_ALOWER, $urandom_range(0, 300), 0, 0,
						$urandom(), 0));
					2: send_word(make_write(K_WR_AUPPER, $urandom_range(0, 300), 0, 0,
						$urandom(), 0));
					3: send_word(make_write(K_WR_TYPE, $urandom(), 0, 0, $urandom(), 0));
					4: send_word(make_write($urandom_range(K_WR_LMAP, K_WR_UMAP),
						$urandom_range(0, 600), $urandom(), $urandom(), $urandom(), 0));
					5: send_word(make_write(K_WR_RANGE, $urandom_range(0, 600),
						$urandom(), $urandom(), $urandom(), 0));
					default: send_word(make_write($urandom_range(KIND_UNUSED_FIRST,
						KIND_UNUSED_LAST), $urandom(), $urandom(), $urandom(), $urandom(), 1));
				endcase
			end
		end
	endtask

	// The low and high ASCII blocks are loaded; queries never reach the rest.
	task automatic test_ascii_load();
		for (int i = 0; i < ASCII_SIZE; i++) begin
			if (i >= ASC_LOW_END && i < ASC_HIGH_START) continue;
			send_word(make_write(K_WR_ACLASS, i, 0, 0, $urandom(), 0));
			send_word(make_write(K_WR_ALOWER, i, 0, 0, $urandom(), 0));
			send_word(make_write(K_WR_AUPPER, i, 0, 0, $urandom(), 0));
		end
	endtask

	// Field extremes, negative code points and empty tables.
	task automatic test_directed();
		logic [31:0] cps [6] = '{32'd0, 32'd255, 32'd256, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF};
		foreach (cps[i]) begin
			send_word(make_query(K_CLASS_Q, cps[i]));
			send_word(make_query(K_LOWER_Q, cps[i]));
			send_word(make_query(K_UPPER_Q, cps[i]));
		end
		// Writes past the end of a table are dropped.
		send_word(make_write(K_WR_ACLASS, 16383, 0, 0, 32'hFFFF_FFFF, 0));
		send_word(make_write(K_WR_RANGE, 512, 1000, 2000, 32'h1234, 1));
		send_word(make_write(K_WR_UMAP, 9999, 1000, 2000, 32'h1234, 0));
		send_word(make_write(KIND_UNUSED_LAST, 0, 0, 0, 0, 0));
		send_word(make_query(K_CLASS_Q, 32'd1));
		send_word(make_query(K_UPPER_Q, 32'd250));
	endtask

	// Small tables, a type-data store that runs out, light stalls.
	task automatic test_small_tables();
		stall_mode = 1;
		write_reg(CFG_TYPE_WORDS, 15'd24);
		load_ranges(8, 40, 60);
		write_reg(CFG_RANGE_COUNT, 15'd8);
		write_reg(CFG_LOWER_COUNT, 15'd8);
		write_reg(CFG_UPPER_COUNT, 15'd7);
		random_traffic(100);
	endtask

	// Larger tables, count bits above the width, a long receiver hold-off, heavy stalls.
	task automatic test_larger_tables();
		stall_mode = 0;
		gap_max = 0;
		write_reg(CFG_TYPE_WORDS, 15'h7FFF);
		load_ranges(BIG_TABLE, 1 << 22, 20);
		write_reg(CFG_RANGE_COUNT, 15'h7C28);
		write_reg(CFG_LOWER_COUNT, 15'(BIG_TABLE));
		write_reg(CFG_UPPER_COUNT, 15'(BIG_TABLE - 1));
		hold_req = 1;
		random_traffic(40);
		drain();
		stall_mode = 2;
		gap_max = 6;
		random_traffic(80);
	endtask

	// One range, no type data, register bits above the count width.
	task automatic test_edge_counts();
		stall_mode = 1;
		write_reg(CFG_TYPE_WORDS, 15'd0);
		send_word(make_write(K_WR_RANGE, 0, 300, 400, 32'hA5A5_0001, 1));
		write_reg(CFG_RANGE_COUNT, 15'h7C01);
		write_reg(CFG_LOWER_COUNT, 15'd0);
		write_reg(CFG_UPPER_COUNT, 15'd1);
		send_word(make_query(K_CLASS_Q, 32'd350));
		send_word(make_query(K_LOWER_Q, 32'd350));
		random_traffic(40);
	endtask

	initial begin
		span_cnt = 0; lower_cnt = 0; upper_cnt = 0; type_avail = 0;
		next_type = 0; types_filled = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		write_reg(CFG_RANGE_COUNT, 15'd0);
		write_reg(CFG_LOWER_COUNT, 15'd0);
		write_reg(CFG_UPPER_COUNT, 15'd0);
		write_reg(CFG_TYPE_WORDS, 15'd0);
		test_ascii_load();
		test_directed();
		test_small_tables();
		test_larger_tables();
		test_edge_counts();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d queries, %0d table writes, %0d register writes; %0d answers checked",
			n_queries, n_writes, n_cfg, n_checked);
		$display("tables from empty to forty entries, masked counts, type data exhausted and absent");
		if (errors == 0 && answers_due.size() == 0)
			$display("rune_class_and_case_lookup regression: pass");
		else
			$display("rune_class_and_case_lookup regression: fail");
		$finish;
	end

endmodule
